>>> hdl/assert_macros.svh
// Assertion macros shared by the ring deque modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/ord_pkg.sv
// Package with types and constants for the overwriting ring deque.
`timescale 1ns / 1ps

package ord_pkg;

  localparam int MAX_DEPTH_DEF  = 16;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int CAP_W          = 5;
  localparam int CAP_RESET      = 16;
  localparam int DATA_W         = 32;

  // Result status codes
  localparam logic STAT_OK        = 1'b0;
  localparam logic STAT_EMPTY_POP = 1'b1;

  typedef enum logic [1:0] {
    MODE_PUSH      = 2'd0,
    MODE_POP_FRONT = 2'd1,
    MODE_POP_BACK  = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [DATA_W-1:0]  push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  pop_value;
    logic                      status;
    logic                      is_empty;
    logic                      is_full;
  } out_item_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;       // carry out the accepted operation now
    logic load_read;  // capture the store read data as the popped word
    logic cfg_write;  // take the capacity write and empty the buffer
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_read; // current item is a pop that returns a stored word
  } sts_t;

endpackage

>>> hdl/overwriting_ring_deque.sv
// Top level of the overwriting ring deque.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one operation per
//   transfer: push to back, pop from front or pop from back. Each accepted
//   operation yields exactly one result on out_valid/out_ready/out_data with
//   the popped word, a status bit and the empty/full flags after the operation.
//   A push into a full buffer overwrites the oldest entry.
//   A push, an empty pop or an unknown mode has its result registered in the
//   cycle after acceptance; a pop that returns a stored word passes through
//   the registered read port of the entry store and the read wait state first.
//   One item per cycle for pushes while the receiver takes each result; a pop
//   that returns a stored word blocks new items until its result is loaded.
//   The cfg channel writes the capacity (1..MAX_DEPTH, saturated) and empties
//   the buffer; write it only while no operation is in flight.
//   Sync reset (rst_n low) empties the buffer, capacity min(16, MAX_DEPTH).
//   If the receiver stalls, the result holds in the output register and the
//   next item is not accepted until that result is transferred.

module overwriting_ring_deque
  import ord_pkg::*;
#(
  parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  ord_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ord_dp #(
    .MAX_DEPTH  (MAX_DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

>>> hdl/ord_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ord_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/ord_dp.sv
// Datapath: pointers, full flag, capacity, entry store and result register.
`timescale 1ns / 1ps

module ord_dp
  import ord_pkg::*;
#(
  parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  in_item_t         in_data,
  input  logic [CAP_W-1:0] cfg_data,
  output out_item_t        out_data
);

  `include "assert_macros.svh"

  localparam int PTR_W      = $clog2(MAX_DEPTH);
  localparam int RESET_CAP  = (CAP_RESET > MAX_DEPTH) ? MAX_DEPTH : CAP_RESET;
  localparam int RESET_LAST = RESET_CAP - 1;

  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [PTR_W-1:0]      tail_r, tail_nxt;
  logic                  full_r, full_nxt;
  logic [PTR_W-1:0]      last_r, last_nxt;
  out_item_t             out_item_r, out_item_nxt;

  logic [PTR_W-1:0]      inc_head, inc_tail, dec_tail;
  logic                  empty;
  logic                  op_status;
  logic                  ram_we, ram_re;
  logic [PTR_W-1:0]      ram_raddr;
  logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;

  // Wrap-around pointer steps within the active capacity
  assign inc_head = (head_r == last_r) ? '0 : head_r + 1'b1;
  assign inc_tail = (tail_r == last_r) ? '0 : tail_r + 1'b1;
  assign dec_tail = (tail_r == '0) ? last_r : tail_r - 1'b1;
  assign empty    = (head_r == tail_r) && !full_r;

  assign ram_wdata = WORD_WIDTH'(unsigned'(in_data.push_value));

  // Decode the operation into pointer updates and store accesses
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    full_nxt  = full_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = head_r;
    op_status = STAT_OK;
    case (in_data.mode)
      MODE_PUSH: begin
        ram_we = 1'b1;
        if (!full_r) begin
          tail_nxt = inc_tail;
          full_nxt = (inc_tail == head_r);
        end else begin
          // overwrite the oldest entry and drag the head along
          head_nxt = inc_head;
          tail_nxt = inc_head;
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          op_status = STAT_EMPTY_POP;
        end else begin
          full_nxt  = 1'b0;
          ram_re    = 1'b1;
          ram_raddr = head_r;
          head_nxt  = inc_head;
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          op_status = STAT_EMPTY_POP;
        end else begin
          full_nxt  = 1'b0;
          ram_re    = 1'b1;
          ram_raddr = dec_tail;
          tail_nxt  = dec_tail;
        end
      end
      default: begin
      end
    endcase
  end

  assign sts.needs_read = (in_data.mode inside {MODE_POP_FRONT, MODE_POP_BACK}) && !empty;

  // Saturate the capacity write to 1..MAX_DEPTH and keep it as a last index
  always_comb begin
    if (cfg_data == '0) begin
      last_nxt = '0;
    end else if (32'(cfg_data) > MAX_DEPTH) begin
      last_nxt = PTR_W'(MAX_DEPTH - 1);
    end else begin
      last_nxt = PTR_W'(cfg_data - 1'b1);
    end
  end

  // Hold pointers, flag and capacity; clear the buffer on a capacity write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      full_r <= 1'b0;
      last_r <= PTR_W'(RESET_LAST);
    end else if (cmd.cfg_write) begin
      head_r <= '0;
      tail_r <= '0;
      full_r <= 1'b0;
      last_r <= last_nxt;
    end else if (cmd.exec) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      full_r <= full_nxt;
    end
  end

  // Build the result: flags at execute, popped word once the store answers
  always_comb begin
    out_item_nxt = out_item_r;
    if (cmd.exec) begin
      out_item_nxt.pop_value = '1;
      out_item_nxt.status    = op_status;
      out_item_nxt.is_empty  = (head_nxt == tail_nxt) && !full_nxt;
      out_item_nxt.is_full   = full_nxt;
    end
    if (cmd.load_read) begin
      out_item_nxt.pop_value = DATA_W'(signed'(ram_rdata));
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_data = out_item_r;

  ord_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (MAX_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we && cmd.exec),
    .wr_addr (tail_r),
    .wr_data (ram_wdata),
    .rd_en   (ram_re && cmd.exec),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  `ASSERT_IMPL(a_full_meets, full_r, head_r == tail_r)
  `ASSERT_IMPL(a_head_in_range, 1'b1, head_r <= last_r)
  `ASSERT_IMPL(a_tail_in_range, 1'b1, tail_r <= last_r)

endmodule

>>> hdl/ord_ctrl.sv
// Controller: handshakes, store read wait state and result valid flag.
`timescale 1ns / 1ps

module ord_ctrl
  import ord_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  logic cfg_valid,
  output logic cfg_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  `include "assert_macros.svh"

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Drive handshakes and datapath commands
  always_comb begin
    in_ready      = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
    cfg_ready     = (state_r == ST_IDLE);
    cmd.exec      = in_valid && in_ready;
    cmd.load_read = (state_r == ST_READ);
    cmd.cfg_write = cfg_valid && cfg_ready;
  end

  // Advance to the read wait state when a pop needs the store
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.exec && sts.needs_read) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Raise valid when a result is loaded, drop it after the transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if ((cmd.exec && !sts.needs_read) || cmd.load_read) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_NEXT(a_pop_waits, cmd.exec && sts.needs_read, state_r == ST_READ)
  `ASSERT_IMPL(a_read_slot_free, state_r == ST_READ, !out_valid_r)
  `ASSERT_NEXT(a_read_delivers, state_r == ST_READ, out_valid_r && state_r == ST_IDLE)

endmodule
